/* sv/mscs_pkg.sv */
package mscs_pkg;

    localparam logic signed [32:0] MAX_S32 = 33'sd2147483647;
    localparam logic signed [32:0] MIN_S32 = -33'sd2147483648;

    localparam logic [1:0] REG_SPRING  = 2'd0;
    localparam logic [1:0] REG_DAMPING = 2'd1;
    localparam logic [1:0] REG_STEP    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPRING,
        ST_DAMP,
        ST_NET,
        ST_DIV,
        ST_VEL,
        ST_POSMUL,
        ST_POS,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* sv/mass_spring_chain_step_core.sv */
// Hair strand integrator: one semi-implicit Euler step per vertex.
// Input channel (valid/ready) carries one vertex per transaction, in strand
// order. Output channel (valid/ready) carries updated vertices. A vertex is
// emitted once its successor has been taken; a vertex with strand_end set
// emits the held vertex (if any) and then itself with final_vertex high.
// Each input vertex takes its spring and damping terms through one shared
// multiplier. Each emitted vertex then takes three axes in turn (net force,
// a 49-step radix-2 divider pass, velocity, position product, position sum)
// and then loads the output. The block is not ready while a vertex is in
// work. A result waits in the output register until taken; while the
// receiver stalls the sequencer waits before it writes the next result, so
// nothing is dropped.
// Configuration writes (cfg_we, cfg_index, cfg_data) are taken at once and
// must only occur while the block is idle.
// Reset restores spring_stiffness 1.0, damping_gain 0, time_step 655 and
// empties the held-vertex slot.
module mass_spring_chain_step_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] ext_force_x,
    input  logic signed [31:0] ext_force_y,
    input  logic signed [31:0] ext_force_z,
    input  logic [31:0] vertex_mass,
    input  logic        vertex_enabled,
    input  logic        strand_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_pos_z,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic        final_vertex
);
    import mscs_pkg::*;

    logic [30:0] k_reg, dg_reg;
    logic [16:0] dt_reg;

    state_t state_reg, state_next;

    // Current vertex.
    logic signed [31:0] cpos_reg [3];
    logic signed [31:0] cvel_reg [3];
    logic signed [31:0] cext_reg [3];
    logic signed [31:0] cspr_reg [3];
    logic signed [31:0] cdmp_reg [3];
    logic [31:0] cmass_reg;
    logic        cen_reg, clast_reg;
    // Held vertex.
    logic signed [31:0] hpos_reg [3];
    logic signed [31:0] hvel_reg [3];
    logic signed [31:0] hext_reg [3];
    logic signed [31:0] hspr_reg [3];
    logic signed [31:0] hdmp_reg [3];
    logic [31:0] hmass_reg;
    logic        hen_reg, have_reg;

    logic [1:0]  ax_reg;
    logic        emit_cur_reg;  // 0: emitting held vertex, 1: current
    logic signed [31:0] net_reg, nv_reg;
    logic signed [32:0] dv_val;
    logic [31:0] mres_reg;     // saturated product magnitude-signed result

    // Divider: quotient of |f| * dt (49 bits) by mass.
    logic [48:0] dividend_reg;
    logic [48:0] quot_reg;
    logic [32:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        fneg_reg;

    logic signed [31:0] ores_reg [6];
    logic        ofinal_reg, ovalid_reg;

    // Emitted vertex selection.
    logic signed [31:0] e_pos, e_vel, e_hext, e_hspr, e_hdmp;
    logic [31:0] e_mass;
    logic        e_en;

    always_comb
    begin
        if (emit_cur_reg)
        begin
            e_pos  = cpos_reg[ax_reg];
            e_vel  = cvel_reg[ax_reg];
            e_mass = cmass_reg;
            e_en   = cen_reg;
        end
        else
        begin
            e_pos  = hpos_reg[ax_reg];
            e_vel  = hvel_reg[ax_reg];
            e_mass = hmass_reg;
            e_en   = hen_reg;
        end
        e_hext = hext_reg[ax_reg];
        e_hspr = hspr_reg[ax_reg];
        e_hdmp = hdmp_reg[ax_reg];
    end

    // Shared multiplier: signed 33-bit operand times unsigned 31-bit.
    logic signed [32:0] mul_a;
    logic [30:0]        mul_b;
    logic [32:0]        mul_mag;
    logic [63:0]        mul_p;
    logic [47:0]        mul_sh;
    logic signed [49:0] mul_s;
    logic signed [31:0] mul_q;

    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 31'd0;
        case (state_reg)
            ST_SPRING:
            begin
                mul_a = 33'(cpos_reg[ax_reg]) - 33'(hpos_reg[ax_reg]);
                mul_b = k_reg;
            end
            ST_DAMP:
            begin
                mul_a = 33'(cvel_reg[ax_reg]);
                mul_b = dg_reg;
            end
            ST_NET:
            begin
                mul_a = net_reg[31] ? -33'(net_reg) : 33'(net_reg);
                mul_b = {14'd0, dt_reg};
            end
            ST_POSMUL:
            begin
                mul_a = 33'(nv_reg);
                mul_b = {14'd0, dt_reg};
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 31'd0;
            end
        endcase
        mul_mag = mul_a[32] ? 33'(-mul_a) : 33'(mul_a);
        mul_p   = 64'(mul_mag) * 64'(mul_b);
        mul_sh  = mul_p[63:16];
        mul_s   = mul_a[32] ? -50'(mul_sh) : 50'(mul_sh);
        mul_q   = sat32(66'(mul_s));
    end

    logic [32:0] div_try;
    logic [31:0] div_m;
    assign div_m   = (e_mass == 32'd0) ? 32'd1 : e_mass;
    assign div_try = {rem_reg[31:0], dividend_reg[48]} - {1'b0, div_m};

    // Velocity increment: quotient capped at 2^31, signed, then saturated.
    always_comb
    begin
        if (quot_reg > 49'd2147483648)
            dv_val = fneg_reg ? -33'sd2147483648 : 33'sd2147483647;
        else if (fneg_reg)
            dv_val = -33'(quot_reg[32:0]);
        else
            dv_val = 33'(sat32(66'(quot_reg[32:0])));
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid && in_ready) state_next = ST_SPRING;
            ST_SPRING: state_next = ST_DAMP;
            ST_DAMP:
                if (ax_reg == 2'd2)
                    state_next = (have_reg || clast_reg) ? ST_NET : ST_IDLE;
                else
                    state_next = ST_SPRING;
            ST_NET:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 6'd49) state_next = ST_VEL;
            ST_VEL:    state_next = ST_POSMUL;
            ST_POSMUL: state_next = ST_POS;
            ST_POS:
                if (!ovalid_reg)
                    state_next = (ax_reg == 2'd2) ? ST_OUT : ST_NET;
            ST_OUT:
                if (!ovalid_reg)
                    state_next = (!emit_cur_reg && clast_reg) ? ST_NET : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid    = ovalid_reg;
        new_pos_x    = ores_reg[0];
        new_pos_y    = ores_reg[1];
        new_pos_z    = ores_reg[2];
        new_vel_x    = ores_reg[3];
        new_vel_y    = ores_reg[4];
        new_vel_z    = ores_reg[5];
        final_vertex = ofinal_reg;
    end

    logic signed [34:0] net_sum;
    logic signed [31:0] c_spr, c_dmp;
    always_comb
    begin
        c_spr = emit_cur_reg ? 32'sd0 : cspr_reg[ax_reg];
        c_dmp = emit_cur_reg ? 32'sd0 : cdmp_reg[ax_reg];
        if (emit_cur_reg)
            net_sum = 35'(cext_reg[ax_reg]) + 35'(cspr_reg[ax_reg])
                    - 35'(cdmp_reg[ax_reg]);
        else
            net_sum = 35'(e_hext) + 35'(e_hspr) - 35'(e_hdmp) - 35'(c_spr) + 35'(c_dmp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            k_reg      <= 31'd65536;
            dg_reg     <= 31'd0;
            dt_reg     <= 17'd655;
            have_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SPRING:  k_reg  <= cfg_data;
                    REG_DAMPING: dg_reg <= cfg_data;
                    REG_STEP:    dt_reg <= cfg_data[16:0];
                    default:     ;
                endcase
            end
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_OUT && !ovalid_reg)
            begin
                ovalid_reg <= 1'b1;
                if (emit_cur_reg || !clast_reg)
                begin
                    // Current vertex becomes held, or the strand is closed.
                    have_reg <= !clast_reg;
                end
            end
            if (state_reg == ST_DAMP && ax_reg == 2'd2 && !have_reg && !clast_reg)
                have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cpos_reg[0] <= pos_x; cpos_reg[1] <= pos_y; cpos_reg[2] <= pos_z;
                    cvel_reg[0] <= vel_x; cvel_reg[1] <= vel_y; cvel_reg[2] <= vel_z;
                    cext_reg[0] <= ext_force_x;
                    cext_reg[1] <= ext_force_y;
                    cext_reg[2] <= ext_force_z;
                    cmass_reg <= vertex_mass;
                    cen_reg   <= vertex_enabled;
                    clast_reg <= strand_end;
                    ax_reg    <= 2'd0;
                    emit_cur_reg <= 1'b0;
                end
            end
            ST_SPRING:
                cspr_reg[ax_reg] <= (cen_reg && have_reg) ? sat32(-66'(mul_q)) : 32'sd0;
            ST_DAMP:
            begin
                cdmp_reg[ax_reg] <= cen_reg ? mul_q : 32'sd0;
                if (ax_reg == 2'd2)
                begin
                    ax_reg <= 2'd0;
                    emit_cur_reg <= !have_reg;
                    if (!have_reg && !clast_reg)
                    begin
                        hpos_reg <= cpos_reg; hvel_reg <= cvel_reg;
                        hext_reg <= cext_reg; hmass_reg <= cmass_reg;
                        hen_reg  <= cen_reg;
                        hspr_reg[0] <= cspr_reg[0]; hspr_reg[1] <= cspr_reg[1];
                        hspr_reg[2] <= cspr_reg[2];
                        hdmp_reg[0] <= cdmp_reg[0]; hdmp_reg[1] <= cdmp_reg[1];
                        hdmp_reg[2] <= mul_q & {32{cen_reg}};
                    end
                end
                else
                    ax_reg <= ax_reg + 2'd1;
            end
            ST_NET:
            begin
                net_reg <= sat32(66'(net_sum));
                // Multiplier is set up from the previous net value; the
                // dividend is loaded in the first divider cycle instead.
                cnt_reg <= 6'd0;
                rem_reg <= 33'd0;
                quot_reg <= 49'd0;
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    fneg_reg <= net_reg[31];
                    dividend_reg <= 49'((net_reg[31] ? 33'(-33'(net_reg)) :
                                         33'(net_reg)) * 49'(dt_reg));
                    cnt_reg <= 6'd1;
                end
                else
                begin
                    dividend_reg <= {dividend_reg[47:0], 1'b0};
                    if (!div_try[32])
                    begin
                        rem_reg  <= div_try;
                        quot_reg <= {quot_reg[47:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= {rem_reg[31:0], dividend_reg[48]};
                        quot_reg <= {quot_reg[47:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            ST_VEL:
                nv_reg <= e_en ? sat32(66'(e_vel) + 66'(dv_val)) : 32'sd0;
            ST_POSMUL:
                mres_reg <= mul_q;
            ST_POS:
            begin
                if (!ovalid_reg)
                begin
                    ores_reg[ax_reg] <= e_en ? sat32(66'(e_pos) + 66'($signed(mres_reg)))
                                             : e_pos;
                    ores_reg[3'd3 + 3'(ax_reg)] <= nv_reg;
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ofinal_reg <= emit_cur_reg;
                    if (!emit_cur_reg)
                    begin
                        if (clast_reg)
                            emit_cur_reg <= 1'b1;
                        else
                        begin
                            hpos_reg <= cpos_reg; hvel_reg <= cvel_reg;
                            hext_reg <= cext_reg; hmass_reg <= cmass_reg;
                            hen_reg  <= cen_reg;
                            hspr_reg <= cspr_reg; hdmp_reg <= cdmp_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

/* tb/mscs_checker.sv */
`timescale 1ns / 100ps

module mscs_checker
    import mscs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] ext_force_x,
    input  logic signed [31:0] ext_force_y,
    input  logic signed [31:0] ext_force_z,
    input  logic [31:0] vertex_mass,
    input  logic        vertex_enabled,
    input  logic        strand_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic signed [31:0] new_pos_x,
    input  logic signed [31:0] new_pos_y,
    input  logic signed [31:0] new_pos_z,
    input  logic signed [31:0] new_vel_x,
    input  logic signed [31:0] new_vel_y,
    input  logic signed [31:0] new_vel_z,
    input  logic        final_vertex,
    output int          fail_count,
    output int          pending_count,
    output int          emitted_count
);

    typedef struct packed {
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic               fin;
    } vertex_out_t;

    typedef logic signed [31:0] vec3_t [3];

    vertex_out_t expected_vertices[$];

    logic [30:0] stiffness;
    logic [30:0] damping;
    logic [16:0] dt;

    vec3_t       held_pos, held_vel, held_frc, held_spr, held_dmp;
    logic [31:0] held_m;
    logic        held_en;
    logic        holding;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q16.16 product, truncated toward zero; b is always below 2^31.
    function automatic longint qmul(longint a, longint unsigned b);
        longint unsigned m;
        longint r;
        m = ((a < 0 ? -a : a) * b) >> 16;
        r = longint'(m);
        return clamp32(a < 0 ? -r : r);
    endfunction

    function automatic longint delta_vel(longint f, logic [31:0] mass);
        longint unsigned m, q;
        m = (mass == 0) ? 1 : mass;
        q = ((f < 0 ? -f : f) * longint'(dt)) / m;
        if (q > 64'd2147483648)
            q = 64'd2147483648;
        return clamp32(f < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic vertex_out_t integrate(vec3_t p, vec3_t v, longint f[3],
                                              logic [31:0] mass, logic en,
                                              logic fin);
        vertex_out_t r;
        longint nv[3], np[3];
        for (int i = 0; i < 3; i++)
        begin
            nv[i] = 0;
            np[i] = p[i];
            if (en)
            begin
                nv[i] = clamp32(longint'(v[i]) + delta_vel(f[i], mass));
                np[i] = clamp32(longint'(p[i]) + qmul(nv[i], dt));
            end
        end
        r.px = np[0]; r.py = np[1]; r.pz = np[2];
        r.vx = nv[0]; r.vy = nv[1]; r.vz = nv[2];
        r.fin = fin;
        return r;
    endfunction

    task automatic take_vertex(vec3_t p, vec3_t v, vec3_t e, logic [31:0] mass,
                               logic en, logic last);
        vec3_t  spr, dmp;
        longint net[3];
        for (int i = 0; i < 3; i++)
        begin
            spr[i] = 0;
            dmp[i] = 0;
            if (en)
            begin
                if (holding)
                    spr[i] = clamp32(-qmul(longint'(p[i]) - held_pos[i], stiffness));
                dmp[i] = qmul(v[i], damping);
            end
        end
        if (holding)
        begin
            for (int i = 0; i < 3; i++)
                net[i] = held_en ? clamp32(longint'(held_frc[i]) + held_spr[i]
                                           - held_dmp[i] - spr[i] + dmp[i]) : 0;
            expected_vertices.push_back(integrate(held_pos, held_vel, net, held_m,
                                                  held_en, 1'b0));
        end
        if (last)
        begin
            for (int i = 0; i < 3; i++)
                net[i] = en ? clamp32(longint'(e[i]) + spr[i] - dmp[i]) : 0;
            expected_vertices.push_back(integrate(p, v, net, mass, en, 1'b1));
            holding = 1'b0;
        end
        else
        begin
            held_pos = p; held_vel = v; held_frc = e;
            held_spr = spr; held_dmp = dmp;
            held_m = mass; held_en = en;
            holding = 1'b1;
        end
    endtask

    assign pending_count = expected_vertices.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec3_t p, v, e;
        vertex_out_t got, want;
        if (!rst_n)
        begin
            stiffness = 31'd65536;
            damping = '0;
            dt = 17'd655;
            holding = 1'b0;
            held_en = 1'b0;
            held_m = '0;
            for (int i = 0; i < 3; i++)
            begin
                held_pos[i] = 0; held_vel[i] = 0; held_frc[i] = 0;
                held_spr[i] = 0; held_dmp[i] = 0;
            end
            expected_vertices.delete();
            fail_count = 0;
            emitted_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_SPRING)
                    stiffness = cfg_data;
                else if (cfg_index == REG_DAMPING)
                    damping = cfg_data;
                else if (cfg_index == REG_STEP)
                    dt = cfg_data[16:0];
            end
            // Check the output first: a result leaving now was predicted earlier.
            if (out_valid && out_ready)
            begin
                got = '{new_pos_x, new_pos_y, new_pos_z,
                        new_vel_x, new_vel_y, new_vel_z, final_vertex};
                emitted_count++;
                if (expected_vertices.size() == 0)
                begin
                    $display("%0t: unexpected output vertex, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: vertex mismatch, expected pos %0d %0d %0d vel %0d %0d %0d fin %0b",
                                 $time, want.px, want.py, want.pz, want.vx, want.vy,
                                 want.vz, want.fin);
                        $display("%0t:                  actual pos %0d %0d %0d vel %0d %0d %0d fin %0b",
                                 $time, got.px, got.py, got.pz, got.vx, got.vy,
                                 got.vz, got.fin);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                p[0] = pos_x; p[1] = pos_y; p[2] = pos_z;
                v[0] = vel_x; v[1] = vel_y; v[2] = vel_z;
                e[0] = ext_force_x; e[1] = ext_force_y; e[2] = ext_force_z;
                take_vertex(p, v, e, vertex_mass, vertex_enabled, strand_end);
            end
        end
    end

endmodule

/* tb/tb_mass_spring_chain_step_core.sv */
`timescale 1ns / 100ps

module tb_mass_spring_chain_step_core;
    import mscs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SPRING;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
    logic signed [31:0] ext_force_x = 0, ext_force_y = 0, ext_force_z = 0;
    logic [31:0] vertex_mass = 32'd65536;
    logic        vertex_enabled = 1'b0;
    logic        strand_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
    logic signed [31:0] new_vel_x, new_vel_y, new_vel_z;
    logic        final_vertex;

    int fail_count, pending_count, emitted_count;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_output = 1'b0;
    int vertices_sent = 0;

    always #6 clk = ~clk;

    mass_spring_chain_step_core dut (.*);

    mscs_checker checker_i (.*);

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        int held_cycles;
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                for (held_cycles = 0; held_cycles < 900; held_cycles++)
                    @(negedge clk);
                hold_output = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_field();
        case ($urandom_range(7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hffffffff;
            3: return $urandom;
            default: return $urandom_range(32'h00004000, 32'h00040000);
        endcase
    endfunction

    // Valid stays high from one transaction to the next unless the sender idles.
    task automatic send_vertex(logic signed [31:0] p[3], logic signed [31:0] v[3],
                               logic signed [31:0] f[3], logic [31:0] mass,
                               logic en, logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        {pos_x, pos_y, pos_z} <= {p[0], p[1], p[2]};
        {vel_x, vel_y, vel_z} <= {v[0], v[1], v[2]};
        {ext_force_x, ext_force_y, ext_force_z} <= {f[0], f[1], f[2]};
        vertex_mass <= mass;
        vertex_enabled <= en;
        strand_end <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        vertices_sent++;
    endtask

    task automatic send_random_vertex(logic last);
        logic signed [31:0] p[3], v[3], f[3];
        for (int i = 0; i < 3; i++)
        begin
            p[i] = rand_field();
            v[i] = rand_field();
            f[i] = rand_field();
        end
        send_vertex(p, v, f, rand_mass(), $urandom_range(9) != 0, last);
    endtask

    task automatic send_strand(int length);
        for (int k = 0; k < length; k++)
            send_random_vertex(k == length - 1);
    endtask

    // Drain, then allow the divider loop time before touching registers.
    task automatic wait_quiet();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (pending_count != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [30:0] value);
        cfg_index <= index;
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        logic signed [31:0] p[3], v[3], f[3];
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, pinned vertices, single-vertex and plain strands.
        for (int i = 0; i < 3; i++)
        begin
            p[i] = 32'sh7fffffff; v[i] = 32'sh7fffffff; f[i] = 32'sh7fffffff;
        end
        send_vertex(p, v, f, 32'd1, 1'b1, 1'b1);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = 32'sh80000000; v[i] = 32'sh80000000; f[i] = 32'sh80000000;
        end
        send_vertex(p, v, f, 32'd0, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            p[i] = 32'sh7fffffff; v[i] = 32'sh7fffffff; f[i] = 32'sh7fffffff;
        end
        send_vertex(p, v, f, 32'hffffffff, 1'b1, 1'b0);
        send_vertex(p, v, f, 32'd65536, 1'b0, 1'b0);
        send_vertex(p, v, f, 32'd65536, 1'b1, 1'b1);
        send_vertex(p, v, f, 32'd65536, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++)
            send_strand(1 + k);
        wait_quiet();

        // Register extremes with short strands.
        write_reg(REG_SPRING, 31'h7fffffff);
        write_reg(REG_DAMPING, 31'h7fffffff);
        write_reg(REG_STEP, 31'd65536);
        send_strand(3);
        send_strand(2);
        wait_quiet();
        write_reg(REG_SPRING, 31'd0);
        write_reg(REG_DAMPING, 31'd0);
        write_reg(REG_STEP, 31'h1ffff);
        send_strand(3);
        wait_quiet();
        write_reg(REG_STEP, 31'd1);
        send_strand(2);
        wait_quiet();

        // Random phases, cycling through four idling mixes, each with its own register setting.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 61; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 61; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            wait_quiet();
            write_reg(REG_SPRING, $urandom_range(0, 32'h00040000));
            write_reg(REG_DAMPING, $urandom_range(0, 32'h00020000));
            write_reg(REG_STEP, $urandom_range(1, 65536));
            if (phase == 4)
                hold_output = 1'b1;
            while (vertices_sent < 1275 * (phase + 1) / 8)
                send_strand($urandom_range(1, 12));
        end

        wait_quiet();
        $display("Sent %0d vertices in strands of 1 to 12, %0d results checked,",
                 vertices_sent, emitted_count);
        $display("across register extremes and idle, stall and back-pressure phases.");
        if (fail_count == 0 && pending_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Timeout");
        $display("Test completed with failures");
        $finish;
    end

endmodule
